// ----- rtl/core/ilid_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ilid_pkg : shared types and constants of the indexed list unit
// Operation and status codes, field widths and the control bundle that the
// top level hands to every list cell.
// ----------------------------------------------------------------------------
package ilid_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_W     = 32;
  localparam int OP_W       = 3;
  localparam int POS_W      = 7;
  localparam int STATUS_W   = 2;
  localparam int LENOUT_W   = 7;
  localparam int LEN_W      = $clog2(CAPACITY + 1);
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CMP_W      = (POS_W > LEN_W) ? POS_W : LEN_W;
  localparam int TREE_LVL   = IDX_W;
  localparam int TREE_LEAF  = 2 ** TREE_LVL;
  localparam int CNT_W      = $clog2(TREE_LVL + 1);
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;

  localparam logic [DATA_W-1:0] RD_MISS = '1;

  typedef enum logic [OP_W-1:0] {
    OP_READ = 3'd0,
    OP_HEAD = 3'd1,
    OP_TAIL = 3'd2,
    OP_AT   = 3'd3,
    OP_DEL  = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  // per-cycle command to the cell row
  typedef struct packed {
    logic              ins;
    logic              del;
    logic [CMP_W-1:0]  pos;
    logic [DATA_W-1:0] data;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/core/ilid_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ilid_cell : one slot of the list
// Holds one value; shifts from a neighbour on insert and delete, loads the new
// value on insert, and offers its value to the read tree when addressed.
// ----------------------------------------------------------------------------
module ilid_cell (
  input  wire logic                          clk,
  input  wire logic [ilid_pkg::IDX_W-1:0]    idx,
  input  wire ilid_pkg::cell_ctl_t           ctl,
  input  wire logic [ilid_pkg::CMP_W-1:0]    rd_pos,
  input  wire logic [ilid_pkg::DATA_W-1:0]   left_val,
  input  wire logic [ilid_pkg::DATA_W-1:0]   right_val,
  output logic      [ilid_pkg::DATA_W-1:0]   val,
  output logic      [ilid_pkg::DATA_W-1:0]   rd_val
);

  logic [ilid_pkg::DATA_W-1:0] val_r;
  logic [ilid_pkg::DATA_W-1:0] val_nxt;
  logic [ilid_pkg::CMP_W-1:0]  idx_x;

  assign idx_x = ilid_pkg::CMP_W'(idx);

  always_comb begin
    val_nxt = val_r;
    if (ctl.ins) begin
      if (idx_x > ctl.pos) begin
        val_nxt = left_val;
      end else if (idx_x == ctl.pos) begin
        val_nxt = ctl.data;
      end
    end else if (ctl.del) begin
      if (idx_x >= ctl.pos) begin
        val_nxt = right_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val    = val_r;
  assign rd_val = (idx_x == rd_pos) ? val_r : '0;

endmodule
`default_nettype wire

// ----- rtl/core/ilid_read_tree.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ilid_read_tree : registered OR tree over the cell read taps
// Binary tree, one register level per stage; at most one tap is non-zero,
// so the root carries the addressed value once it has passed every level.
// ----------------------------------------------------------------------------
module ilid_read_tree (
  input  wire logic                        clk,
  input  wire logic [ilid_pkg::DATA_W-1:0] leaf_i [ilid_pkg::CAPACITY],
  output logic      [ilid_pkg::DATA_W-1:0] root_o
);

  localparam int NODES = ilid_pkg::TREE_LEAF - 1;
  localparam int HALF  = ilid_pkg::TREE_LEAF / 2;

  logic [ilid_pkg::DATA_W-1:0] leaf [ilid_pkg::TREE_LEAF];
  logic [ilid_pkg::DATA_W-1:0] node_r [1:NODES];

  // pad to a power of two
  always_comb begin
    for (int j = 0; j < ilid_pkg::TREE_LEAF; j++) begin
      leaf[j] = (j < ilid_pkg::CAPACITY) ? leaf_i[j] : '0;
    end
  end

  // heap order: node n has children 2n and 2n+1
  for (genvar n = 1; n <= NODES; n++) begin : g_node
    if (n >= HALF) begin : g_bottom
      always_ff @(posedge clk) begin
        node_r[n] <= leaf[2*n - ilid_pkg::TREE_LEAF] | leaf[2*n + 1 - ilid_pkg::TREE_LEAF];
      end
    end else begin : g_inner
      always_ff @(posedge clk) begin
        node_r[n] <= node_r[2*n] | node_r[2*n + 1];
      end
    end
  end

  assign root_o = node_r[1];

endmodule
`default_nettype wire

// ----- rtl/core/indexed_list_insert_delete_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_list_insert_delete_unit : ordered list with positional insert/delete
// A row of CAPACITY cells holds the list; insert and delete shift cells from
// the position on at once. Reads use a registered OR tree over the cell taps.
// ----------------------------------------------------------------------------
//
//  channel | dir | beat contents (tdata, low bit first)
//  --------+-----+-----------------------------------------------------------
//  in_     | in  | operation[2:0], position[9:3], data_in[41:10], zero pad
//  out_    | out | data_out[31:0], status[33:32], length_now[40:34], zero pad
//
//  Insert, append, insert-at, delete and unused codes: result registered on
//    the accepting edge.
//  Read: the result waits for the registered OR tree to settle and for a free
//    result slot; no new beat is taken meanwhile.
//  Reset empties the list (length zero); cell contents are not cleared,
//    only entries below the length can be seen.
//  A waiting result does not block the input as long as out_tready is high
//    in that cycle; otherwise the input stalls until the result slot frees.
//
module indexed_list_insert_delete_unit (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // operation, position, data_in
  input  wire logic [ilid_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // data_out, status, length_now
  output logic      [ilid_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  localparam int CAP = ilid_pkg::CAPACITY;

  // input fields
  ilid_pkg::op_t                   in_op;
  logic [ilid_pkg::POS_W-1:0]      in_pos;
  logic [ilid_pkg::DATA_W-1:0]     in_data;

  assign in_op   = ilid_pkg::op_t'(in_tdata[2:0]);
  assign in_pos  = in_tdata[9:3];
  assign in_data = in_tdata[41:10];

  // control state
  ilid_pkg::state_t                state_r, state_nxt;
  logic [ilid_pkg::LEN_W-1:0]      length_r, length_nxt;
  logic [ilid_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                            out_tvalid_r, out_tvalid_nxt;

  // read context and result payload
  logic [ilid_pkg::CMP_W-1:0]      rd_pos_r, rd_pos_nxt;
  logic                            rd_oor_r, rd_oor_nxt;
  logic [ilid_pkg::DATA_W-1:0]     res_data_r, res_data_nxt;
  ilid_pkg::status_t               res_status_r, res_status_nxt;
  logic [ilid_pkg::LENOUT_W-1:0]   res_len_r, res_len_nxt;

  logic                            accept;
  logic                            slot_free;
  logic                            full;
  logic [ilid_pkg::CMP_W-1:0]      pos_x;
  logic [ilid_pkg::CMP_W-1:0]      len_x;
  ilid_pkg::cell_ctl_t             ctl;
  logic [ilid_pkg::DATA_W-1:0]     tree_root;

  assign slot_free = !out_tvalid_r || out_tready;
  assign in_tready = (state_r == ilid_pkg::S_IDLE) && slot_free;
  assign accept    = in_tvalid && in_tready;
  assign pos_x     = ilid_pkg::CMP_W'(in_pos);
  assign len_x     = ilid_pkg::CMP_W'(length_r);
  assign full      = (length_r >= ilid_pkg::LEN_W'(CAP));

  always_comb begin
    state_nxt      = state_r;
    length_nxt     = length_r;
    cnt_nxt        = cnt_r;
    rd_pos_nxt     = rd_pos_r;
    rd_oor_nxt     = rd_oor_r;
    res_data_nxt   = res_data_r;
    res_status_nxt = res_status_r;
    res_len_nxt    = res_len_r;
    out_tvalid_nxt = out_tready ? 1'b0 : out_tvalid_r;
    ctl.ins        = 1'b0;
    ctl.del        = 1'b0;
    ctl.pos        = pos_x;
    ctl.data       = in_data;

    case (state_r)
      ilid_pkg::S_IDLE: begin
        if (accept) begin
          res_data_nxt   = '0;
          res_status_nxt = ilid_pkg::ST_DONE;
          case (in_op)
            ilid_pkg::OP_READ: begin
              // result leaves once the tree has settled
              rd_pos_nxt = pos_x;
              rd_oor_nxt = (pos_x >= len_x);
              cnt_nxt    = ilid_pkg::CNT_W'(ilid_pkg::TREE_LVL);
              state_nxt  = ilid_pkg::S_READ;
            end
            ilid_pkg::OP_HEAD, ilid_pkg::OP_TAIL: begin
              ctl.pos = (in_op == ilid_pkg::OP_HEAD) ? '0 : len_x;
              if (full) begin
                res_status_nxt = ilid_pkg::ST_FULL;
              end else begin
                ctl.ins = 1'b1;
              end
            end
            ilid_pkg::OP_AT: begin
              // range check takes priority over full
              if (pos_x > len_x) begin
                res_status_nxt = ilid_pkg::ST_RANGE;
              end else if (full) begin
                res_status_nxt = ilid_pkg::ST_FULL;
              end else begin
                ctl.ins = 1'b1;
              end
            end
            ilid_pkg::OP_DEL: begin
              if (pos_x < len_x) begin
                ctl.del = 1'b1;
              end else begin
                res_status_nxt = ilid_pkg::ST_RANGE;
              end
            end
            default: begin
              // unused code: list untouched, plain done
            end
          endcase
          if (ctl.ins) begin
            length_nxt = length_r + ilid_pkg::LEN_W'(1);
          end else if (ctl.del) begin
            length_nxt = length_r - ilid_pkg::LEN_W'(1);
          end
          res_len_nxt = ilid_pkg::LENOUT_W'(length_nxt);
          if (in_op != ilid_pkg::OP_READ) begin
            out_tvalid_nxt = 1'b1;
          end
        end
      end
      ilid_pkg::S_READ: begin
        if (cnt_r != '0) begin
          cnt_nxt = cnt_r - ilid_pkg::CNT_W'(1);
        end else if (slot_free) begin
          // cells and read position are frozen, so the root holds steady
          res_data_nxt   = rd_oor_r ? ilid_pkg::RD_MISS : tree_root;
          res_status_nxt = rd_oor_r ? ilid_pkg::ST_RANGE : ilid_pkg::ST_DONE;
          res_len_nxt    = ilid_pkg::LENOUT_W'(length_r);
          out_tvalid_nxt = 1'b1;
          state_nxt      = ilid_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ilid_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ilid_pkg::S_IDLE;
      length_r     <= '0;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      length_r     <= length_nxt;
      cnt_r        <= cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_pos_r     <= rd_pos_nxt;
    rd_oor_r     <= rd_oor_nxt;
    res_data_r   <= res_data_nxt;
    res_status_r <= res_status_nxt;
    res_len_r    <= res_len_nxt;
  end

  // cell row
  logic [ilid_pkg::DATA_W-1:0] cell_val [CAP];
  logic [ilid_pkg::DATA_W-1:0] cell_rd  [CAP];

  for (genvar i = 0; i < CAP; i++) begin : g_cell
    logic [ilid_pkg::DATA_W-1:0] left_v;
    logic [ilid_pkg::DATA_W-1:0] right_v;

    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = cell_val[i-1];
    end
    if (i == CAP - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = cell_val[i+1];
    end

    ilid_cell u_cell (
      .clk       (clk),
      .idx       (ilid_pkg::IDX_W'(i)),
      .ctl       (ctl),
      .rd_pos    (rd_pos_r),
      .left_val  (left_v),
      .right_val (right_v),
      .val       (cell_val[i]),
      .rd_val    (cell_rd[i])
    );
  end

  ilid_read_tree u_tree (
    .clk    (clk),
    .leaf_i (cell_rd),
    .root_o (tree_root)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'd0, res_len_r, res_status_r, res_data_r};

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_len_bound : assert property (@(posedge clk) disable iff (!rst_n)
    length_r <= ilid_pkg::LEN_W'(CAP))
    else $error("list length beyond capacity");

  a_read_waits : assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_op == ilid_pkg::OP_READ) |=> (state_r == ilid_pkg::S_READ) && !in_tready)
    else $error("read did not enter tree wait");

  a_full_len : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && (res_status_r == ilid_pkg::ST_FULL)
      |-> (res_len_r == ilid_pkg::LENOUT_W'(CAP)))
    else $error("full status with spare room");

  a_del_len : assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_op == ilid_pkg::OP_DEL) && (pos_x < len_x)
      |=> length_r == $past(length_r) - ilid_pkg::LEN_W'(1))
    else $error("delete did not shorten list");

  a_ins_len : assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins |=> length_r == $past(length_r) + ilid_pkg::LEN_W'(1))
    else $error("insert did not lengthen list");

endmodule
`default_nettype wire

// ----- tb/sv/ilid_list_checker.sv -----
// ----------------------------------------------------------------------------
// ilid_list_checker : result checker for the indexed list unit
// Watches both stream channels. It keeps its own copy of the list, works out
// the result of every accepted input beat, and compares each output beat
// with the oldest result still owed.
// ----------------------------------------------------------------------------
module ilid_list_checker (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  input  wire logic                             in_tready,
  input  wire logic [ilid_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  wire logic                             out_tvalid,
  input  wire logic                             out_tready,
  input  wire logic [ilid_pkg::OUT_TDATA_W-1:0] out_tdata,
  output int                                    fail_count,
  output int                                    results_owed,
  output int                                    list_len
);

  typedef struct packed {
    logic [ilid_pkg::DATA_W-1:0]   data_out;
    ilid_pkg::status_t             status;
    logic [ilid_pkg::LENOUT_W-1:0] length_now;
  } list_result_t;

  logic [ilid_pkg::DATA_W-1:0] shadow [ilid_pkg::CAPACITY];
  int                          shadow_len = 0;
  list_result_t                owed_q [$];
  int                          errs = 0;

  // range check comes before the full check
  function automatic ilid_pkg::status_t place_value(int at,
                                                    logic [ilid_pkg::DATA_W-1:0] value);
    int i;
    if (at > shadow_len) return ilid_pkg::ST_RANGE;
    if (shadow_len >= ilid_pkg::CAPACITY) return ilid_pkg::ST_FULL;
    for (i = shadow_len; i > at; i--) shadow[i] = shadow[i-1];
    shadow[at] = value;
    shadow_len++;
    return ilid_pkg::ST_DONE;
  endfunction

  function automatic list_result_t step_list(logic [ilid_pkg::OP_W-1:0] op, int pos,
                                             logic [ilid_pkg::DATA_W-1:0] value);
    list_result_t r;
    int           i;
    r.data_out = '0;
    r.status   = ilid_pkg::ST_DONE;
    case (op)
      ilid_pkg::OP_READ: begin
        if (pos < shadow_len) begin
          r.data_out = shadow[pos];
        end else begin
          r.data_out = ilid_pkg::RD_MISS;
          r.status   = ilid_pkg::ST_RANGE;
        end
      end
      ilid_pkg::OP_HEAD: r.status = place_value(0, value);
      ilid_pkg::OP_TAIL: r.status = place_value(shadow_len, value);
      ilid_pkg::OP_AT:   r.status = place_value(pos, value);
      ilid_pkg::OP_DEL: begin
        if (pos < shadow_len) begin
          for (i = pos; i + 1 < shadow_len; i++) shadow[i] = shadow[i+1];
          shadow_len--;
        end else begin
          r.status = ilid_pkg::ST_RANGE;
        end
      end
      default: ; // spare codes leave the list alone
    endcase
    r.length_now = ilid_pkg::LENOUT_W'(shadow_len);
    return r;
  endfunction

  always @(posedge clk) begin : check_beats
    list_result_t got;
    list_result_t want;
    if (!rst_n) begin
      owed_q.delete();
      shadow_len = 0;
    end else begin
      // an output beat always belongs to an earlier input beat
      if (out_tvalid && out_tready) begin
        got.data_out   = out_tdata[ilid_pkg::DATA_W-1:0];
        got.status     = ilid_pkg::status_t'(out_tdata[ilid_pkg::DATA_W +: ilid_pkg::STATUS_W]);
        got.length_now = out_tdata[ilid_pkg::DATA_W+ilid_pkg::STATUS_W +: ilid_pkg::LENOUT_W];
        if (owed_q.size() == 0) begin
          errs++;
          $display("%0t: unexpected result beat, expected none, actual %h",
                   $time, out_tdata);
        end else begin
          want = owed_q.pop_front();
          if (got.data_out !== want.data_out) begin
            errs++;
            $display("%0t: data_out expected %h actual %h",
                     $time, want.data_out, got.data_out);
          end
          if (got.status !== want.status) begin
            errs++;
            $display("%0t: status expected %0d actual %0d",
                     $time, want.status, got.status);
          end
          if (got.length_now !== want.length_now) begin
            errs++;
            $display("%0t: length_now expected %0d actual %0d",
                     $time, want.length_now, got.length_now);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        owed_q.push_back(step_list(in_tdata[ilid_pkg::OP_W-1:0],
                                   int'(in_tdata[ilid_pkg::OP_W +: ilid_pkg::POS_W]),
                                   in_tdata[ilid_pkg::OP_W+ilid_pkg::POS_W +: ilid_pkg::DATA_W]));
      end
    end
    fail_count   <= errs;
    results_owed <= owed_q.size();
    list_len     <= shadow_len;
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top : testbench of the indexed list unit
// Drives operation beats into the list, first a short directed run over the
// corner cases, then biased random runs that fill the list to capacity and
// empty it again, under several idle and stall patterns. The checker beside
// the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

  // spare operation codes, ignored by the block
  localparam logic [ilid_pkg::OP_W-1:0] OP_SPARE_A = 3'd5;
  localparam logic [ilid_pkg::OP_W-1:0] OP_SPARE_B = 3'd6;
  localparam logic [ilid_pkg::OP_W-1:0] OP_SPARE_C = 3'd7;

  localparam int SEG_BEATS     = 165;  // beats per random segment
  localparam int HOLD_CYCLES   = 150;  // long receiver hold-off
  localparam int TAIL_CYCLES   = 20;   // settling time before the verdict
  localparam int QUIET_LIMIT   = 2000; // cycles with no beat on either side

  logic                             clk        = 1'b0;
  logic                             rst_n      = 1'b0;
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  // operation, position, data_in
  logic [ilid_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  // data_out, status, length_now
  logic [ilid_pkg::OUT_TDATA_W-1:0] out_tdata;

  int fail_count;
  int results_owed;
  int list_len;

  int idle_pct  = 0;   // sender idle chance, in percent
  int stall_pct = 0;   // receiver stall chance, in percent
  int hold_ask  = 0;   // bumped to request a long hold-off
  int hold_seen = 0;
  int hold_left = 0;
  int quiet     = 0;

  indexed_list_insert_delete_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  ilid_list_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .fail_count   (fail_count),
    .results_owed (results_owed),
    .list_len     (list_len)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random stalls, or a long hold-off when one is asked for.
  // The hold is counted here so the sender keeps pushing meanwhile.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_ask != hold_seen) begin
      hold_seen  <= hold_ask;
      hold_left  <= HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Watchdog: too long without a beat on either channel ends the run.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet <= 0;
      end else begin
        quiet <= quiet + 1;
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // One input beat. Valid is left high after acceptance so back-to-back
  // beats never see a low-high pair in the same step.
  task automatic send_op(input logic [ilid_pkg::OP_W-1:0] op,
                         input logic [ilid_pkg::POS_W-1:0] pos,
                         input logic [ilid_pkg::DATA_W-1:0] value);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(ilid_pkg::IN_TDATA_W-ilid_pkg::OP_W-ilid_pkg::POS_W-ilid_pkg::DATA_W){1'b0}},
                  value, pos, op};
    do @(posedge clk); while (!in_tready);
  endtask

  // Sender stops until every owed result has come back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
  endtask

  function automatic logic [ilid_pkg::DATA_W-1:0] pick_value();
    logic [ilid_pkg::DATA_W-1:0] v;
    case ($urandom_range(0, 19))
      0:       v = 32'h8000_0000;
      1:       v = 32'h7fff_ffff;
      2:       v = 32'hffff_ffff;
      3:       v = 32'h0000_0000;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Random beat, biased to grow or to shrink the list. Positions mostly sit
  // in 0..length (one past the end included), a tenth span the whole field.
  task automatic send_random(input bit grow);
    logic [ilid_pkg::OP_W-1:0]  op;
    logic [ilid_pkg::POS_W-1:0] pos;
    int                         roll;
    roll = $urandom_range(0, 99);
    if (roll < (grow ? 70 : 20)) begin
      op = ilid_pkg::OP_W'($urandom_range(ilid_pkg::OP_HEAD, ilid_pkg::OP_AT));
    end else if (roll < (grow ? 85 : 35)) begin
      op = ilid_pkg::OP_READ;
    end else if (roll < 95) begin
      op = ilid_pkg::OP_DEL;
    end else begin
      op = ilid_pkg::OP_W'($urandom_range(OP_SPARE_A, OP_SPARE_C));
    end
    if ($urandom_range(0, 9) == 0) begin
      pos = ilid_pkg::POS_W'($urandom_range(0, 127));
    end else begin
      pos = ilid_pkg::POS_W'($urandom_range(0, list_len));
    end
    send_op(op, pos, pick_value());
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed: empty list, spare codes, edges of the value range ---
    send_op(ilid_pkg::OP_READ, 7'd0,   32'h1234_5678);  // read of empty list
    send_op(ilid_pkg::OP_DEL,  7'd0,   32'h0);          // delete of empty list
    send_op(ilid_pkg::OP_AT,   7'd1,   32'h5555_5555);  // insert past length
    send_op(ilid_pkg::OP_AT,   7'd127, 32'haaaa_aaaa);
    send_op(OP_SPARE_A,        7'd0,   32'hffff_ffff);
    send_op(OP_SPARE_B,        7'd64,  32'h8000_0000);
    send_op(OP_SPARE_C,        7'd127, 32'h7fff_ffff);
    send_op(ilid_pkg::OP_HEAD, 7'd99,  32'h8000_0000);
    send_op(ilid_pkg::OP_TAIL, 7'd0,   32'h7fff_ffff);
    send_op(ilid_pkg::OP_AT,   7'd1,   32'h0000_0000);  // into the middle
    send_op(ilid_pkg::OP_AT,   7'd3,   32'hffff_ffff);  // at length: appends
    send_op(ilid_pkg::OP_HEAD, 7'd0,   32'h0000_0001);
    send_op(ilid_pkg::OP_READ, 7'd0,   32'h0);
    send_op(ilid_pkg::OP_READ, 7'd4,   32'h0);          // last entry
    send_op(ilid_pkg::OP_READ, 7'd5,   32'h0);          // one past the end
    send_op(ilid_pkg::OP_READ, 7'd127, 32'h0);
    send_op(ilid_pkg::OP_DEL,  7'd127, 32'h0);          // delete past the end
    send_op(ilid_pkg::OP_DEL,  7'd2,   32'h0);
    send_op(ilid_pkg::OP_DEL,  7'd0,   32'h0);
    send_op(ilid_pkg::OP_DEL,  7'd2,   32'h0);          // tail entry
    send_op(ilid_pkg::OP_READ, 7'd1,   32'h0);
    drain_results();

    // --- random: per idle and stall pattern, fill towards capacity then empty ---
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 57; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 57; end
        default: begin idle_pct = 8;  stall_pct = 8;  end
      endcase
      for (int n = 0; n < SEG_BEATS; n++) begin
        if (n == 60 && (mode == 0 || mode == 2)) hold_ask <= hold_ask + 1;
        send_random(1'b1);
      end
      drain_results();
      for (int n = 0; n < SEG_BEATS; n++) send_random(1'b0);
      drain_results();
    end

    // let any stray beat surface before the verdict
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
